// ===== sv/udsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsm_pkg
// Shared types, constants and the arctangent table for the disk sample map.
// ----------------------------------------------------------------------------
package udsm_pkg;

    // Sample mapping modes carried on tuser
    typedef enum logic {
        OP_CONCENTRIC = 1'b0,
        OP_AREA       = 1'b1
    } op_t;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int DIV_STEPS     = 30;
    localparam int SQRT_STEPS    = 16;

    localparam logic signed [31:0] GAIN_Q30  = 32'sd652032874;
    localparam logic signed [63:0] ROUND_ADD = 64'sd8796093022208; // half of 2^44

    // Front pipeline word: divider and square root lanes side by side
    typedef struct packed {
        logic        valid;
        logic        area;
        logic        zero_ang;
        logic        flip;
        logic [1:0]  quad;
        logic [29:0] quo;
        logic [16:0] rem;
        logic [15:0] den;
        logic [16:0] radius;
        logic [14:0] area_turn;
        logic [31:0] sq_n;
        logic [17:0] sq_rem;
        logic [15:0] sq_root;
    } front_t;

    // Polar word handed to the rotator
    typedef struct packed {
        logic        valid;
        logic [16:0] radius;
        logic [31:0] ang;
    } polar_t;

    // Arctangent of 2^-i as a binary angle, one full turn is 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/uniform_disk_sample_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_disk_sample_map
// Maps a square sample onto the unit disk, concentric or equal-area polar.
// ----------------------------------------------------------------------------
// Pipeline: one prep stage, 30 radix-2 divider stages (square root runs in
//   the first 16 alongside), one rotator load stage, the CORDIC stages,
//   quadrant fold, gain multiply and round/clamp.
// Throughput: one word per cycle; the whole pipe holds while a result waits.
// Reset: synchronous active-low aresetn clears all valid bits; data needs none.
module uniform_disk_sample_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_u, [31:16] sample_v
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] disk_x, [31:16] disk_y
);

    logic adv;
    logic signed [15:0] a, b;
    logic signed [16:0] ab_sum;
    logic [16:0] abs_a, abs_b;
    udsm_pkg::front_t prep;
    udsm_pkg::front_t pipe_reg [0:udsm_pkg::DIV_STEPS];
    udsm_pkg::polar_t pol;
    logic [31:0] base, qext;
    logic rot_valid;
    logic signed [15:0] rot_x, rot_y;

    // Advance the whole pipe whenever the output slot is free or taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign a      = s_tdata[15:0];
    assign b      = s_tdata[31:16];
    assign ab_sum = 17'(a) + 17'(b);
    assign abs_a  = a[15] ? (17'd0 - 17'(a)) : {1'b0, a};
    assign abs_b  = b[15] ? (17'd0 - 17'(b)) : {1'b0, b};

    // Pick the region, the ratio operands and the base angle
    always_comb begin
        prep           = '0;
        prep.valid     = s_tvalid;
        prep.area      = (s_tuser == udsm_pkg::OP_AREA);
        prep.area_turn = b[15] ? 15'd0 : b[14:0];
        prep.sq_n      = a[15] ? 32'd0 : {2'b00, a[14:0], 15'b0};
        if (!ab_sum[16] && (ab_sum != 17'sd0)) begin
            if (a > b) begin
                prep.quad   = 2'd0;
                prep.radius = abs_a;
                prep.rem    = abs_b;
                prep.den    = abs_a[15:0];
                prep.flip   = b[15];
            end else begin
                prep.quad   = 2'd1;
                prep.radius = abs_b;
                prep.rem    = abs_a;
                prep.den    = abs_b[15:0];
                prep.flip   = !a[15];
            end
        end else begin
            if (a < b) begin
                prep.quad   = 2'd2;
                prep.radius = abs_a;
                prep.rem    = abs_b;
                prep.den    = abs_a[15:0];
                prep.flip   = !b[15];
            end else begin
                prep.quad     = 2'd3;
                prep.radius   = abs_b;
                prep.rem      = abs_a;
                prep.den      = abs_b[15:0];
                prep.flip     = !(a[15] ^ b[15]);
                prep.zero_ang = (b == 16'sd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg[0].valid <= 1'b0;
        end else if (adv) begin
            pipe_reg[0] <= prep;
        end
    end

    // One quotient bit per stage; one root bit per stage in the first stages
    for (genvar k = 0; k < udsm_pkg::DIV_STEPS; k++) begin : g_front
        udsm_pkg::front_t nx;
        logic [19:0] sq_cur, sq_try;

        always_comb begin
            nx     = pipe_reg[k];
            sq_cur = {pipe_reg[k].sq_rem, pipe_reg[k].sq_n[31:30]};
            sq_try = {2'b00, pipe_reg[k].sq_root, 2'b01};
            if (pipe_reg[k].rem >= {1'b0, pipe_reg[k].den}) begin
                nx.quo = {pipe_reg[k].quo[28:0], 1'b1};
                nx.rem = 17'(pipe_reg[k].rem - {1'b0, pipe_reg[k].den}) << 1;
            end else begin
                nx.quo = {pipe_reg[k].quo[28:0], 1'b0};
                nx.rem = pipe_reg[k].rem << 1;
            end
            if (k < udsm_pkg::SQRT_STEPS) begin
                nx.sq_n = pipe_reg[k].sq_n << 2;
                if (sq_cur >= sq_try) begin
                    nx.sq_rem  = 18'(sq_cur - sq_try);
                    nx.sq_root = {pipe_reg[k].sq_root[14:0], 1'b1};
                end else begin
                    nx.sq_rem  = sq_cur[17:0];
                    nx.sq_root = {pipe_reg[k].sq_root[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k+1].valid <= 1'b0;
            end else if (adv) begin
                pipe_reg[k+1] <= nx;
            end
        end
    end

    // Form radius and binary angle for the rotator
    assign base = {pipe_reg[udsm_pkg::DIV_STEPS].quad, 30'b0};
    assign qext = {2'b00, pipe_reg[udsm_pkg::DIV_STEPS].quo};

    always_comb begin
        pol.valid = pipe_reg[udsm_pkg::DIV_STEPS].valid;
        if (pipe_reg[udsm_pkg::DIV_STEPS].area) begin
            pol.radius = {1'b0, pipe_reg[udsm_pkg::DIV_STEPS].sq_root};
            pol.ang    = {pipe_reg[udsm_pkg::DIV_STEPS].area_turn, 17'b0};
        end else begin
            pol.radius = pipe_reg[udsm_pkg::DIV_STEPS].radius;
            if (pipe_reg[udsm_pkg::DIV_STEPS].zero_ang) begin
                pol.ang = '0;
            end else if (pipe_reg[udsm_pkg::DIV_STEPS].flip) begin
                pol.ang = base - qext;
            end else begin
                pol.ang = base + qext;
            end
        end
    end

    udsm_rotator u_rotator (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .pol       (pol),
        .out_valid (rot_valid),
        .out_x     (rot_x),
        .out_y     (rot_y)
    );

    assign m_tvalid = rot_valid;
    assign m_tdata  = {rot_y, rot_x};

endmodule

// ===== sv/udsm_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsm_rotator
// Pipelined CORDIC rotation, quadrant fold, gain multiply, round and clamp.
// ----------------------------------------------------------------------------
module udsm_rotator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  udsm_pkg::polar_t   pol,
    output logic               out_valid,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y
);

    typedef struct packed {
        logic               valid;
        logic [1:0]         quad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rot_t;

    typedef struct packed {
        logic               valid;
        logic signed [63:0] px;
        logic signed [63:0] py;
    } prod_t;

    rot_t  rot_reg [0:udsm_pkg::CORDIC_N];
    rot_t  fold_reg;
    prod_t prod_reg;
    logic  out_valid_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;

    function automatic logic signed [15:0] round_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        logic signed [19:0] t;
        s = p + udsm_pkg::ROUND_ADD;
        t = s[63:44];
        if (t > 20'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -20'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // Load start vector (r * 2^14, 0) and the angle within the quadrant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0].valid <= 1'b0;
        end else if (adv) begin
            rot_reg[0].valid <= pol.valid;
        end
        if (adv) begin
            rot_reg[0].quad <= pol.ang[31:30];
            rot_reg[0].x    <= signed'({1'b0, pol.radius, 14'b0});
            rot_reg[0].y    <= '0;
            rot_reg[0].z    <= signed'({2'b00, pol.ang[29:0]});
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < udsm_pkg::CORDIC_N; k++) begin : g_rot
        logic signed [31:0] dx, dy, at;
        assign dx = rot_reg[k].y >>> k;
        assign dy = rot_reg[k].x >>> k;
        assign at = signed'(udsm_pkg::atan_turn(5'(k)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rot_reg[k+1].valid <= 1'b0;
            end else if (adv) begin
                rot_reg[k+1].valid <= rot_reg[k].valid;
            end
            if (adv) begin
                rot_reg[k+1].quad <= rot_reg[k].quad;
                if (!rot_reg[k].z[31]) begin
                    rot_reg[k+1].x <= rot_reg[k].x - dx;
                    rot_reg[k+1].y <= rot_reg[k].y + dy;
                    rot_reg[k+1].z <= rot_reg[k].z - at;
                end else begin
                    rot_reg[k+1].x <= rot_reg[k].x + dx;
                    rot_reg[k+1].y <= rot_reg[k].y - dy;
                    rot_reg[k+1].z <= rot_reg[k].z + at;
                end
            end
        end
    end

    // Fold back into the right quadrant by quarter turns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg.valid <= 1'b0;
        end else if (adv) begin
            fold_reg.valid <= rot_reg[udsm_pkg::CORDIC_N].valid;
        end
        if (adv) begin
            fold_reg.quad <= rot_reg[udsm_pkg::CORDIC_N].quad;
            fold_reg.z    <= rot_reg[udsm_pkg::CORDIC_N].z;
            unique case (rot_reg[udsm_pkg::CORDIC_N].quad)
                2'd0: begin
                    fold_reg.x <= rot_reg[udsm_pkg::CORDIC_N].x;
                    fold_reg.y <= rot_reg[udsm_pkg::CORDIC_N].y;
                end
                2'd1: begin
                    fold_reg.x <= -rot_reg[udsm_pkg::CORDIC_N].y;
                    fold_reg.y <= rot_reg[udsm_pkg::CORDIC_N].x;
                end
                2'd2: begin
                    fold_reg.x <= -rot_reg[udsm_pkg::CORDIC_N].x;
                    fold_reg.y <= -rot_reg[udsm_pkg::CORDIC_N].y;
                end
                default: begin
                    fold_reg.x <= rot_reg[udsm_pkg::CORDIC_N].y;
                    fold_reg.y <= -rot_reg[udsm_pkg::CORDIC_N].x;
                end
            endcase
        end
    end

    // Remove the CORDIC gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (adv) begin
            prod_reg.valid <= fold_reg.valid;
        end
        if (adv) begin
            prod_reg.px <= 64'(fold_reg.x) * 64'(udsm_pkg::GAIN_Q30);
            prod_reg.py <= 64'(fold_reg.y) * 64'(udsm_pkg::GAIN_Q30);
        end
    end

    // Round half up and clamp into the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= prod_reg.valid;
        end
        if (adv) begin
            out_x_reg <= round_sat(prod_reg.px);
            out_y_reg <= round_sat(prod_reg.py);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

endmodule

// ===== sv/udsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsm_checker
// Port-level checks on the disk sample map, bound to the top level.
// ----------------------------------------------------------------------------
module udsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word shown straight after reset");

    // A waiting result word holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // An empty output slot never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output slot empty");

    // The input stalls only behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind uniform_disk_sample_map udsm_checker u_udsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
